[hdl/lets_pkg.sv]
// Package for the least-elapsed thread scheduler: sizes, codes and the
// structs that pass between the controller and the slot cells. No dependencies.
`default_nettype none
package lets_pkg;
	localparam int NUM_SLOTS    = 16;
	localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
	localparam int ELAPSED_BITS = 16;
	localparam int ID_BITS      = 8;
	localparam int ORDER_BITS   = 8;
	localparam int BLOCK_BITS   = ID_BITS + 1;
	localparam int CNT_BITS     = SLOT_BITS + 1;

	localparam logic [ORDER_BITS-1:0]   ORDER_LIMIT = '1;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
	localparam logic [BLOCK_BITS-1:0]   BLOCK_NONE  = '1;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_EXIT   = 2'd2,
		CMD_JOIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUN     = 2'd0,
		ST_BLOCK   = 2'd1,
		ST_DONE    = 2'd2,
		ST_DESTROY = 2'd3
	} thr_st_t;

	typedef enum logic [1:0] {
		RES_OK        = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_FULL      = 2'd2
	} res_t;

	typedef enum logic [2:0] {
		OP_NONE       = 3'd0,
		OP_CREATE     = 3'd1,
		OP_EXIT       = 3'd2,
		OP_JOIN_DONE  = 3'd3,
		OP_JOIN_BLOCK = 3'd4,
		OP_SCHED      = 3'd5,
		OP_RANK_STEP  = 3'd6,
		OP_RANK_LOAD  = 3'd7
	} op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		op_t                   op;
		logic [SLOT_BITS-1:0]  sel;
		logic [SLOT_BITS-1:0]  run_slot;
		logic                  found;
		logic [ID_BITS-1:0]    target;
		logic                  want;
		logic [ID_BITS-1:0]    new_tid;
		logic [ORDER_BITS-1:0] order;
		logic                  p_valid;
		logic [ORDER_BITS-1:0] p_order;
		logic [SLOT_BITS-1:0]  p_idx;
	} bcast_t;

	// search word handed from cell to cell
	typedef struct packed {
		logic                    free_found;
		logic [SLOT_BITS-1:0]    free_slot;
		logic                    tgt_found;
		logic [SLOT_BITS-1:0]    tgt_slot;
		logic                    best_found;
		logic [SLOT_BITS-1:0]    best_slot;
		logic [ELAPSED_BITS-1:0] best_e;
		logic [ORDER_BITS-1:0]   best_o;
	} carry_t;

	typedef struct packed {
		logic                  valid;
		thr_st_t               status;
		logic [ID_BITS-1:0]    tid;
		logic [ORDER_BITS-1:0] order;
	} view_t;
endpackage
`default_nettype wire

[hdl/lets_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
`default_nettype none
interface lets_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] target_id;
	logic       want_value;
	modport source(output valid, cmd, target_id, want_value, input ready);
	modport sink(input valid, cmd, target_id, want_value, output ready);
endinterface

interface lets_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] running_id;
	logic       switched;
	logic [7:0] new_id;
	modport source(output valid, status, running_id, switched, new_id, input ready);
	modport sink(input valid, status, running_id, switched, new_id, output ready);
endinterface
`default_nettype wire

[hdl/lets_cell.sv]
// One thread slot: holds the entry, applies broadcast updates and adds
// its entry to the search word passed along the chain. Uses lets_pkg.
`default_nettype none
module lets_cell (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  [lets_pkg::SLOT_BITS-1:0]     idx,
	input  lets_pkg::bcast_t                   bc,
	input  lets_pkg::carry_t                   cin,
	output lets_pkg::carry_t                   cout,
	output lets_pkg::view_t                    view
);
	logic                              valid_q;
	lets_pkg::thr_st_t                 status_q;
	logic [lets_pkg::ID_BITS-1:0]      tid_q;
	logic [lets_pkg::ELAPSED_BITS-1:0] elapsed_q;
	logic [lets_pkg::BLOCK_BITS-1:0]   blocker_q;
	logic                              jv_q;
	logic [lets_pkg::ORDER_BITS-1:0]   order_q;
	logic [lets_pkg::SLOT_BITS-1:0]    rank_q;
	lets_pkg::carry_t                  carry_q;
	lets_pkg::carry_t                  nxt;
	logic                              waiting, is_run, is_sel, beats_rank;

	assign waiting = valid_q && (idx != bc.run_slot);
	assign is_run  = (idx == bc.run_slot);
	assign is_sel  = (idx == bc.sel);
	assign beats_rank = bc.p_valid && (bc.p_idx != idx) &&
		((bc.p_order < order_q) || ((bc.p_order == order_q) && (bc.p_idx < idx)));

	always_comb begin
		nxt = cin;
		if (!cin.free_found && !valid_q) begin
			nxt.free_found = 1'b1;
			nxt.free_slot  = idx;
		end
		if (!cin.tgt_found && waiting && (tid_q == bc.target)) begin
			nxt.tgt_found = 1'b1;
			nxt.tgt_slot  = idx;
		end
		if (waiting && (status_q == lets_pkg::ST_RUN) && (!cin.best_found ||
			(elapsed_q < cin.best_e) ||
			((elapsed_q == cin.best_e) && (order_q < cin.best_o)))) begin
			nxt.best_found = 1'b1;
			nxt.best_slot  = idx;
			nxt.best_e     = elapsed_q;
			nxt.best_o     = order_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= (idx == '0);
			status_q  <= lets_pkg::ST_RUN;
			tid_q     <= '0;
			elapsed_q <= '0;
			blocker_q <= lets_pkg::BLOCK_NONE;
			jv_q      <= 1'b0;
			order_q   <= '0;
			rank_q    <= '0;
		end else begin
			rank_q <= '0;
			case (bc.op)
				lets_pkg::OP_CREATE: begin
					if (is_sel) begin
						valid_q   <= 1'b1;
						status_q  <= lets_pkg::ST_RUN;
						tid_q     <= bc.new_tid;
						elapsed_q <= '0;
						blocker_q <= lets_pkg::BLOCK_NONE;
						jv_q      <= 1'b0;
						order_q   <= bc.order;
					end
				end
				lets_pkg::OP_EXIT: begin
					// exit carries the running thread's id in the target field
					if (is_run) begin
						status_q <= jv_q ? lets_pkg::ST_DESTROY : lets_pkg::ST_DONE;
					end else if (valid_q && (status_q == lets_pkg::ST_BLOCK) &&
						(blocker_q == {1'b0, bc.target})) begin
						status_q  <= lets_pkg::ST_RUN;
						blocker_q <= lets_pkg::BLOCK_NONE;
					end
				end
				lets_pkg::OP_JOIN_DONE: begin
					if (is_sel && bc.want) status_q <= lets_pkg::ST_DESTROY;
				end
				lets_pkg::OP_JOIN_BLOCK: begin
					if (is_run) begin
						status_q  <= lets_pkg::ST_BLOCK;
						blocker_q <= {1'b0, bc.target};
					end
					if (is_sel) jv_q <= bc.want;
				end
				lets_pkg::OP_SCHED: begin
					if (waiting && (status_q == lets_pkg::ST_DESTROY)) valid_q <= 1'b0;
					if (bc.found && is_run) begin
						if (elapsed_q != lets_pkg::ELAPSED_MAX) elapsed_q <= elapsed_q + 1'b1;
						order_q <= bc.order;
					end
				end
				lets_pkg::OP_RANK_STEP: begin
					rank_q <= rank_q + (beats_rank ? 1'b1 : 1'b0);
				end
				lets_pkg::OP_RANK_LOAD: begin
					if (valid_q) order_q <= lets_pkg::ORDER_BITS'(rank_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign cout        = carry_q;
	assign view.valid  = valid_q;
	assign view.status = status_q;
	assign view.tid    = tid_q;
	assign view.order  = order_q;
endmodule
`default_nettype wire

[hdl/least_elapsed_thread_scheduler.sv]
// Least-elapsed thread scheduler: controller plus a chain of slot cells.
// Uses lets_pkg, lets_req_if, lets_rsp_if and lets_cell.
//
// Usage: commands enter on req (cmd, target_id, want_value) with a
// valid/ready handshake; each command gives exactly one beat on rsp
// (status, running_id, switched, new_id).
// A search word moves through the sixteen cells one per cycle; each
// cell registers it. Create and tick take one search, exit adds an update
// step (S_PRE) first, a join that blocks takes two searches. A result
// state (S_FIN) then loads the output; when the queue order counter
// reaches its limit, a rank pass (S_RANK) runs before it. One command is
// in work at a time; the next is taken as soon as the controller is
// idle, even while the previous result beat still waits.
// Reset: slot 0 holds running thread 0, all others are free, next id 1.
// A stalled rsp holds its beat; a finished command waits until the
// output register is free.
`default_nettype none
module least_elapsed_thread_scheduler (
	input wire        clk,
	input wire        arst_n,
	lets_req_if.sink  req,
	lets_rsp_if.source rsp
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PRE  = 5'b00010,
		S_SCAN = 5'b00100,
		S_RANK = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                             state_q;
	lets_pkg::cmd_t                     cmd_q;
	logic [lets_pkg::ID_BITS-1:0]       tgt_q;
	logic                               want_q;
	logic                               sched_q;
	logic [lets_pkg::CNT_BITS-1:0]      cnt_q;
	logic [lets_pkg::CNT_BITS-1:0]      n_q;
	logic [lets_pkg::SLOT_BITS-1:0]     run_q;
	logic [lets_pkg::ORDER_BITS-1:0]    order_q;
	logic [lets_pkg::ID_BITS:0]         next_id_q;
	lets_pkg::res_t                     res_st_q;
	logic [lets_pkg::ID_BITS-1:0]       res_run_q;
	logic                               res_sw_q;
	logic [lets_pkg::ID_BITS-1:0]       res_new_q;
	logic                               out_valid_q;
	logic [1:0]                         out_st_q;
	logic [7:0]                         out_run_q;
	logic                               out_sw_q;
	logic [7:0]                         out_new_q;

	lets_pkg::bcast_t                   bc;
	lets_pkg::carry_t                   carry [lets_pkg::NUM_SLOTS];
	lets_pkg::view_t                    view  [lets_pkg::NUM_SLOTS];
	lets_pkg::carry_t                   ce;
	logic                               scan_done, create_ok, enq, rank_go, out_free;
	logic [lets_pkg::ORDER_BITS-1:0]    order_nx;
	logic [lets_pkg::SLOT_BITS-1:0]     probe;

	assign ce        = carry[lets_pkg::NUM_SLOTS-1];
	assign scan_done = (state_q == S_SCAN) && (cnt_q == lets_pkg::CNT_BITS'(lets_pkg::NUM_SLOTS));
	assign create_ok = ce.free_found && !next_id_q[lets_pkg::ID_BITS];
	assign probe     = cnt_q[lets_pkg::SLOT_BITS-1:0];
	assign order_nx  = order_q + 1'b1;
	assign enq       = (bc.op == lets_pkg::OP_CREATE) ||
		((bc.op == lets_pkg::OP_SCHED) && ce.best_found);
	assign rank_go   = enq && (order_nx == lets_pkg::ORDER_LIMIT);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		bc          = '0;
		bc.op       = lets_pkg::OP_NONE;
		bc.run_slot = run_q;
		bc.target   = (state_q == S_PRE) ? view[run_q].tid : tgt_q;
		bc.want     = want_q;
		bc.new_tid  = next_id_q[lets_pkg::ID_BITS-1:0];
		bc.order    = order_q;
		bc.p_valid  = view[probe].valid;
		bc.p_order  = view[probe].order;
		bc.p_idx    = probe;
		case (state_q)
			S_PRE: bc.op = lets_pkg::OP_EXIT;
			S_SCAN: begin
				if (scan_done) begin
					if (sched_q) begin
						bc.op    = lets_pkg::OP_SCHED;
						bc.found = ce.best_found;
					end else if (cmd_q == lets_pkg::CMD_CREATE) begin
						bc.sel = ce.free_slot;
						if (create_ok) bc.op = lets_pkg::OP_CREATE;
					end else if (ce.tgt_found) begin
						bc.sel = ce.tgt_slot;
						bc.op  = (view[ce.tgt_slot].status == lets_pkg::ST_DONE) ?
							lets_pkg::OP_JOIN_DONE : lets_pkg::OP_JOIN_BLOCK;
					end
				end
			end
			S_RANK: begin
				bc.op = (cnt_q == lets_pkg::CNT_BITS'(lets_pkg::NUM_SLOTS)) ?
					lets_pkg::OP_RANK_LOAD : lets_pkg::OP_RANK_STEP;
				if (cnt_q == lets_pkg::CNT_BITS'(lets_pkg::NUM_SLOTS)) bc.p_valid = 1'b0;
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < lets_pkg::NUM_SLOTS; g++) begin : g_cell
		lets_pkg::carry_t cin;
		if (g == 0) begin : g_head
			assign cin = '0;
		end else begin : g_link
			assign cin = carry[g-1];
		end
		lets_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (lets_pkg::SLOT_BITS'(g)),
			.bc     (bc),
			.cin    (cin),
			.cout   (carry[g]),
			.view   (view[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= lets_pkg::CMD_CREATE;
			tgt_q       <= '0;
			want_q      <= 1'b0;
			sched_q     <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			run_q       <= '0;
			order_q     <= lets_pkg::ORDER_BITS'(1);
			next_id_q   <= (lets_pkg::ID_BITS+1)'(1);
			res_st_q    <= lets_pkg::RES_OK;
			res_run_q   <= '0;
			res_sw_q    <= 1'b0;
			res_new_q   <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= '0;
			out_run_q   <= '0;
			out_sw_q    <= 1'b0;
			out_new_q   <= '0;
		end else begin
			// S_FIN loads the output register itself
			if (rsp.ready && (state_q != S_FIN)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q     <= lets_pkg::cmd_t'(req.cmd);
						tgt_q     <= req.target_id;
						want_q    <= req.want_value;
						sched_q   <= (lets_pkg::cmd_t'(req.cmd) == lets_pkg::CMD_TICK);
						cnt_q     <= '0;
						res_st_q  <= lets_pkg::RES_OK;
						res_sw_q  <= 1'b0;
						res_new_q <= '0;
						state_q   <= (lets_pkg::cmd_t'(req.cmd) == lets_pkg::CMD_EXIT) ?
							S_PRE : S_SCAN;
					end
				end
				S_PRE: begin
					sched_q <= 1'b1;
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						res_run_q <= view[run_q].tid;
						state_q   <= rank_go ? S_RANK : S_FIN;
						cnt_q     <= '0;
						n_q       <= '0;
						if (enq) order_q <= order_nx;
						if (sched_q) begin
							if (ce.best_found) begin
								run_q     <= ce.best_slot;
								res_sw_q  <= 1'b1;
								res_run_q <= view[ce.best_slot].tid;
							end
						end else if (cmd_q == lets_pkg::CMD_CREATE) begin
							if (create_ok) begin
								res_new_q <= next_id_q[lets_pkg::ID_BITS-1:0];
								next_id_q <= next_id_q + 1'b1;
							end else begin
								res_st_q <= lets_pkg::RES_FULL;
							end
						end else if (!ce.tgt_found) begin
							res_st_q <= lets_pkg::RES_NOT_FOUND;
						end else if (bc.op == lets_pkg::OP_JOIN_BLOCK) begin
							sched_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_RANK: begin
					if (cnt_q != lets_pkg::CNT_BITS'(lets_pkg::NUM_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						if (view[probe].valid) n_q <= n_q + 1'b1;
					end else begin
						order_q <= lets_pkg::ORDER_BITS'(n_q);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_st_q;
						out_run_q   <= res_run_q;
						out_sw_q    <= res_sw_q;
						out_new_q   <= res_new_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_st_q;
	assign rsp.running_id = out_run_q;
	assign rsp.switched   = out_sw_q;
	assign rsp.new_id     = out_new_q;
endmodule
`default_nettype wire
